// File: src/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg: shared definitions for the sync/length/XOR packet deframer
// Holds the parse phase codes, the reset sync byte and the result record.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhCmd  = 3'd1;
  localparam logic [2:0] PhLen  = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhCsum = 3'd4;

  localparam logic [7:0] SyncByteReset = 8'd170;

  localparam logic ItemPayload = 1'b0;
  localparam logic ItemEnd     = 1'b1;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       checksum_good;
  } sld_result_t;

endpackage

// File: src/sld_parser.sv
// ----------------------------------------------------------------------------
// sld_parser: packet parse state machine
// Updates the parse state for each accepted byte and forms its result.
// ----------------------------------------------------------------------------
module sld_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           sync_byte_i,
  input  logic                 byte_fire_i,
  input  logic [7:0]           byte_i,
  output logic                 res_valid_o,
  output sld_pkg::sld_result_t res_o
);

  logic [2:0] phase_q, phase_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] xor_q, xor_d;
  logic       last_data;

  // Last payload byte when the next index reaches the declared length.
  assign last_data = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    pos_d       = pos_q;
    xor_d       = xor_q;
    res_valid_o = 1'b0;
    res_o.item_kind      = sld_pkg::ItemPayload;
    res_o.command_code   = cmd_q;
    res_o.payload_length = len_q;
    res_o.payload_byte   = 8'd0;
    res_o.payload_index  = 8'd0;
    res_o.checksum_good  = 1'b0;
    case (phase_q)
      sld_pkg::PhCmd: begin
        cmd_d   = byte_i;
        xor_d   = xor_q ^ byte_i;
        phase_d = sld_pkg::PhLen;
      end
      sld_pkg::PhLen: begin
        len_d   = byte_i;
        xor_d   = xor_q ^ byte_i;
        pos_d   = 8'd0;
        phase_d = (byte_i == 8'd0) ? sld_pkg::PhCsum : sld_pkg::PhData;
      end
      sld_pkg::PhData: begin
        xor_d   = xor_q ^ byte_i;
        pos_d   = pos_q + 8'd1;
        if (last_data) begin
          phase_d = sld_pkg::PhCsum;
        end
        res_valid_o         = 1'b1;
        res_o.payload_byte  = byte_i;
        res_o.payload_index = pos_q;
      end
      sld_pkg::PhCsum: begin
        res_valid_o         = 1'b1;
        res_o.item_kind     = sld_pkg::ItemEnd;
        res_o.checksum_good = (byte_i == xor_q);
        phase_d             = sld_pkg::PhIdle;
        pos_d               = 8'd0;
        xor_d               = 8'd0;
      end
      default: begin
        // Idle and unused codes wait for the sync byte.
        phase_d = sld_pkg::PhIdle;
        if (byte_i == sync_byte_i) begin
          phase_d = sld_pkg::PhCmd;
          xor_d   = 8'd0;
          pos_d   = 8'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sld_pkg::PhIdle;
      cmd_q   <= 8'd0;
      len_q   <= 8'd0;
      pos_q   <= 8'd0;
      xor_q   <= 8'd0;
    end else if (byte_fire_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
    end
  end

endmodule

// File: src/sld_out_stage.sv
// ----------------------------------------------------------------------------
// sld_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sld_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  sld_pkg::sld_result_t res_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sld_pkg::sld_result_t res_o
);

  logic                 valid_q, valid_d;
  sld_pkg::sld_result_t res_q;

  // A new result may enter when the register is empty or drains this cycle.
  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: src/sync_len_xor_packet_deframer.sv
// ----------------------------------------------------------------------------
// sync_len_xor_packet_deframer: sync/length/XOR-checksum packet deframer
// Parses a received byte stream into payload and end-of-packet results.
// ----------------------------------------------------------------------------
// The block takes one received byte per request and, while the output does
// not stall, sustains one byte per clock. In idle it waits for the
// programmed sync byte (170 after reset), then reads a command byte, a length
// byte, that many payload bytes and a checksum byte. Each payload byte gives
// one result with its index, the command and the length, in the cycle after
// it is taken; the checksum byte gives an end-of-packet result whose
// checksum_good flag tells whether it matched the XOR of the command, length
// and payload bytes. Sync, command and length bytes give no result. A sync
// byte seen inside a packet is plain data; there is no resynchronization.
// The rate is set by the single result register: a byte is taken whenever
// that register is empty or is being emptied in the same cycle, so a stalled
// output holds the input side back. Write the sync byte only while the block
// is idle.
// ----------------------------------------------------------------------------
module sync_len_xor_packet_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       item_kind_o,
  output logic [7:0] command_code_o,
  output logic [7:0] payload_length_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o,
  output logic       checksum_good_o
);

  logic [7:0]           sync_byte_q;
  logic                 rx_fire;
  logic                 res_valid;
  logic                 can_load;
  sld_pkg::sld_result_t res_new;
  sld_pkg::sld_result_t res_out;

  // The sync byte register is written directly from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_byte_q <= sld_pkg::SyncByteReset;
    end else if (cfg_we_i) begin
      sync_byte_q <= cfg_wdata_i;
    end
  end

  assign rx_ready_o = can_load;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  // The parser state registers advance once per accepted byte.
  sld_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sync_byte_i (sync_byte_q),
    .byte_fire_i (rx_fire),
    .byte_i      (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res_new)
  );

  // Results that a byte produces are captured in the output register.
  sld_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (rx_fire && res_valid),
    .res_i       (res_new),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign item_kind_o      = res_out.item_kind;
  assign command_code_o   = res_out.command_code;
  assign payload_length_o = res_out.payload_length;
  assign payload_byte_o   = res_out.payload_byte;
  assign payload_index_o  = res_out.payload_index;
  assign checksum_good_o  = res_out.checksum_good;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sync/length/XOR packet deframer
// Feeds directed and random byte streams under several sync byte settings,
// predicts every payload and end-of-packet result, and compares them in order.
// ----------------------------------------------------------------------------
module tb_top;

  // Tracks the parser the same way the block does and keeps the results that
  // are still owed by the block, oldest first.
  class deframe_scoreboard;
    logic [7:0]           sync_value;
    logic [2:0]           parse_state;
    logic [7:0]           cur_command;
    logic [7:0]           cur_length;
    logic [7:0]           next_index;
    logic [7:0]           xor_fold;
    sld_pkg::sld_result_t pending_results[$];
    int unsigned          fail_count;

    function new();
      sync_value  = sld_pkg::SyncByteReset;
      parse_state = sld_pkg::PhIdle;
      cur_command = '0;
      cur_length  = '0;
      next_index  = '0;
      xor_fold    = '0;
      fail_count  = 0;
    endfunction

    // Advances the parser by one accepted byte and queues any result it owes.
    function void note_rx_byte(logic [7:0] b);
      sld_pkg::sld_result_t r;
      r = '0;
      case (parse_state)
        sld_pkg::PhCmd: begin
          cur_command = b;
          xor_fold    = xor_fold ^ b;
          parse_state = sld_pkg::PhLen;
        end
        sld_pkg::PhLen: begin
          cur_length  = b;
          xor_fold    = xor_fold ^ b;
          next_index  = '0;
          parse_state = (b == 8'd0) ? sld_pkg::PhCsum : sld_pkg::PhData;
        end
        sld_pkg::PhData: begin
          r.item_kind      = sld_pkg::ItemPayload;
          r.command_code   = cur_command;
          r.payload_length = cur_length;
          r.payload_byte   = b;
          r.payload_index  = next_index;
          r.checksum_good  = 1'b0;
          pending_results.push_back(r);
          xor_fold = xor_fold ^ b;
          if (({1'b0, next_index} + 9'd1) >= {1'b0, cur_length}) begin
            parse_state = sld_pkg::PhCsum;
          end
          next_index = next_index + 8'd1;
        end
        sld_pkg::PhCsum: begin
          r.item_kind      = sld_pkg::ItemEnd;
          r.command_code   = cur_command;
          r.payload_length = cur_length;
          r.checksum_good  = (b == xor_fold);
          pending_results.push_back(r);
          parse_state = sld_pkg::PhIdle;
          next_index  = '0;
          xor_fold    = '0;
        end
        default: begin
          parse_state = sld_pkg::PhIdle;
          if (b == sync_value) begin
            parse_state = sld_pkg::PhCmd;
            xor_fold    = '0;
            next_index  = '0;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(sld_pkg::sld_result_t got);
      sld_pkg::sld_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: kind %0d, byte %0h", got.item_kind,
               got.payload_byte);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("item_kind", {7'd0, want.item_kind}, {7'd0, got.item_kind});
      compare_field("command_code", want.command_code, got.command_code);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_index", want.payload_index, got.payload_index);
      compare_field("checksum_good", {7'd0, want.checksum_good},
                    {7'd0, got.checksum_good});
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       rx_valid_i;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       item_kind_o;
  logic [7:0] command_code_o;
  logic [7:0] payload_length_o;
  logic [7:0] payload_byte_o;
  logic [7:0] payload_index_o;
  logic       checksum_good_o;

  deframe_scoreboard sb = new();

  // Sender pacing: a burst of requests goes out back to back, then a random
  // gap follows. While no_idle_stretch is set the gaps collapse to zero.
  int unsigned burst_left = 0;
  bit          no_idle_stretch = 1'b0;

  // Set by the stimulus to make the result side hold off for a long stretch.
  bit          hold_request = 1'b0;

  sync_len_xor_packet_deframer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .rx_valid_i       (rx_valid_i),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .item_kind_o      (item_kind_o),
    .command_code_o   (command_code_o),
    .payload_length_o (payload_length_o),
    .payload_byte_o   (payload_byte_o),
    .payload_index_o  (payload_index_o),
    .checksum_good_o  (checksum_good_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offers one byte request and returns at the edge where it is taken. The
  // ready line is looked at on the falling edge, where it already holds the
  // value that the next rising edge sees. The valid line is left high so
  // that a following request in the same burst goes out without a bubble;
  // only a gap lowers it.
  task automatic offer_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (no_idle_stretch) gap = 0;
      if (gap != 0) begin
        rx_valid_i <= 1'b0;
        rx_byte_i  <= 8'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(negedge clk_i); while (!rx_ready_o);
    @(posedge clk_i);
    sb.note_rx_byte(b);
  endtask

  // A complete packet with a random command and payload. When bad_sum is set
  // the checksum byte is flipped by a nonzero mask so it can never match.
  task automatic offer_packet(input int unsigned len, input bit bad_sum);
    logic [7:0] cmd;
    logic [7:0] fold;
    logic [7:0] b;
    cmd  = 8'($urandom);
    fold = cmd ^ len[7:0];
    offer_byte(sb.sync_value);
    offer_byte(cmd);
    offer_byte(len[7:0]);
    for (int i = 0; i < len; i++) begin
      b    = 8'($urandom);
      fold = fold ^ b;
      offer_byte(b);
    end
    if (bad_sum) fold = fold ^ 8'($urandom_range(1, 255));
    offer_byte(fold);
  endtask

  // Stops sending, waits for every owed result, then lets the parser finish
  // any byte that gave no result before the next register write.
  task automatic settle_outputs();
    rx_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.sync_value = value;
  endtask

  // Result side: checks every accepted result and paces out_ready_i with a
  // pattern that cycles through always-ready, coin-flip, sparse and periodic
  // modes. A hold request forces ready low before the pattern resumes.
  // The handshake and the fields are taken on the falling edge before the
  // rising edge that accepts them.
  initial begin : result_sink
    int unsigned          tick;
    int unsigned          hold_left;
    bit                   take;
    sld_pkg::sld_result_t got;
    tick      = 0;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      take               = out_valid_o && out_ready_i;
      got.item_kind      = item_kind_o;
      got.command_code   = command_code_o;
      got.payload_length = payload_length_o;
      got.payload_byte   = payload_byte_o;
      got.payload_index  = payload_index_o;
      got.checksum_good  = checksum_good_o;
      @(posedge clk_i);
      if (take) sb.check_result(got);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 80;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case ((tick >> 6) & 3)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((tick & 7) != 0);
        endcase
      end
    end
  end

  // Main stimulus. The directed part runs with the reset sync byte; after it
  // each phase programs a new sync byte and sends mostly well-formed packets,
  // with some ignored noise and some raw random bytes that break packets.
  initial begin : stimulus
    logic [7:0]  directed_bytes [23];
    logic [7:0]  sync_plan [5];
    logic [7:0]  b;
    int unsigned phase_bytes;
    int unsigned pick;
    int unsigned len;
    int unsigned n;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    rx_valid_i  <= 1'b0;
    rx_byte_i   <= '0;

    // Idle noise, then: a zero-length packet, a packet with the sync value
    // inside its payload and a bad checksum, a packet whose command equals
    // the sync value, and one whose checksum byte equals the sync value.
    directed_bytes = '{8'h00, 8'hFF, 8'h55,
                       8'hAA, 8'h00, 8'h00, 8'h00,
                       8'hAA, 8'hFF, 8'h02, 8'hAA, 8'h00, 8'h56,
                       8'hAA, 8'hAA, 8'h01, 8'hFF, 8'h54,
                       8'hAA, 8'h10, 8'h01, 8'hBB, 8'hAA};
    sync_plan[0] = 8'h00;
    sync_plan[1] = 8'hFF;
    sync_plan[2] = 8'($urandom);
    sync_plan[3] = 8'($urandom);
    sync_plan[4] = sld_pkg::SyncByteReset;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_bytes[i]) offer_byte(directed_bytes[i]);
    settle_outputs();

    for (int p = 0; p < 5; p++) begin
      write_sync(sync_plan[p]);
      // Long result-side hold-off while a payload keeps coming, so the
      // result register fills and the input side has to stall.
      if (p == 1) begin
        hold_request = 1'b1;
        offer_packet(30, 1'b0);
      end
      // One packet of the largest length reaches the top payload index.
      if (p == 2) offer_packet(255, 1'($urandom_range(0, 1)));
      phase_bytes = 0;
      while (phase_bytes < 70) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          n = $urandom_range(0, 99);
          if (n < 5) len = 0;
          else if (n < 85) len = $urandom_range(1, 8);
          else if (n < 98) len = $urandom_range(9, 40);
          else len = $urandom_range(200, 255);
          offer_packet(len, $urandom_range(0, 3) == 0);
          phase_bytes += len + 4;
        end else if (pick < 85) begin
          // Bytes that never match the sync value; ignored while idle.
          n = $urandom_range(1, 3);
          repeat (n) begin
            b = 8'($urandom);
            if (b == sb.sync_value) b = ~b;
            offer_byte(b);
          end
        end else begin
          // Raw bytes, often led by a sync byte, giving truncated packets.
          n = $urandom_range(1, 6);
          if ($urandom_range(0, 1) == 1) offer_byte(sb.sync_value);
          repeat (n) offer_byte(8'($urandom));
          phase_bytes += n;
        end
        if ($urandom_range(0, 7) == 0) no_idle_stretch = !no_idle_stretch;
      end
      settle_outputs();
    end

    if (sb.fail_count == 0) begin
      $display("sync_len_xor_packet_deframer: match");
    end else begin
      $display("sync_len_xor_packet_deframer: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("sync_len_xor_packet_deframer: mismatch");
    $finish;
  end

endmodule
